@@ design/cpu8ls_pkg.sv @@
// ----------------------------------------------------------------------------
// cpu8ls_pkg
// Shared types and constants of the 8-bit load/store unit: operation classes,
// bus request codes, target codes and stream field layouts.
// ----------------------------------------------------------------------------
package cpu8ls_pkg;

  // load forms
  typedef enum logic [4:0] {
    OP_MOV_RR    = 5'd0,
    OP_LD_RN     = 5'd1,
    OP_LD_R_HL   = 5'd2,
    OP_ST_HL_R   = 5'd3,
    OP_ST_PAIR_A = 5'd4,
    OP_LD_A_PAIR = 5'd5,
    OP_ST_HLI_A  = 5'd6,
    OP_LD_A_HLI  = 5'd7,
    OP_ST_HLD_A  = 5'd8,
    OP_LD_A_HLD  = 5'd9,
    OP_ST_HL_N   = 5'd10,
    OP_ST_HIN_A  = 5'd11,
    OP_LD_A_HIN  = 5'd12,
    OP_ST_HIC_A  = 5'd13,
    OP_LD_A_HIC  = 5'd14,
    OP_LD_A_NN   = 5'd15,
    OP_ST_NN_A   = 5'd16
  } op_class_e;

  typedef enum logic [1:0] {
    BUS_NONE  = 2'd0,
    BUS_READ  = 2'd1,
    BUS_WRITE = 2'd2
  } bus_op_e;

  // address pair selector
  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;

  // register file indexes
  localparam logic [2:0] REG_A   = 3'd0;
  localparam logic [2:0] REG_B   = 3'd1;
  localparam logic [2:0] REG_C   = 3'd2;
  localparam logic [2:0] REG_D   = 3'd3;
  localparam logic [2:0] REG_E   = 3'd4;
  localparam logic [2:0] REG_H   = 3'd5;
  localparam logic [2:0] REG_L   = 3'd6;
  localparam int unsigned NumRegs = 7;

  // write targets
  localparam logic [3:0] TGT_NONE    = 4'd0;
  localparam logic [3:0] TGT_REG_A   = 4'd1;
  localparam logic [3:0] TGT_REG_L   = 4'd7;
  localparam logic [3:0] TGT_TEMP_LO = 4'd8;
  localparam logic [3:0] TGT_TEMP_HI = 4'd9;

  localparam logic [7:0]  HighPageMsb  = 8'hFF;
  localparam logic [15:0] StackRstVal  = 16'hFFFE;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 56;

  typedef struct packed {
    logic       kind;
    op_class_e  op_class;
    logic [1:0] cycle_index;
    logic [2:0] dest_reg;
    logic [2:0] source_reg;
    logic [1:0] pair_sel;
    logic [7:0] read_byte;
  } in_item_t;

  typedef struct packed {
    bus_op_e     bus_op;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic        done_res;
    logic [15:0] pc_value;
    logic [3:0]  target_written;
    logic [7:0]  target_value;
  } out_item_t;

endpackage

@@ design/cpu8_load_store_unit_top.sv @@
// ----------------------------------------------------------------------------
// cpu8_load_store_unit_top
// Load group of an 8-bit CPU, stepped one machine cycle or read return per
// item; holds the register file, PC, temp word and the pending read target.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata: op,cyc,dst,src,pair,rdata
//                                                 tuser: kind
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata: bus,addr,wdata,done,pc,
//                                                 tgt,tval
//  cfg       in   cfg_we_i                        cfg_wdata_i: stack address
//
//  one item per cycle sustained while the output is not stalled; an accepted
//  item passes through the input register, then the result register
//  the state update for an item happens when it moves into the result register
//  rst_ni clears state, pc, temp word, pending target and both valid flags
//  a stalled output holds its item; the input register keeps accepting while
//  it is empty or moving forward
// ----------------------------------------------------------------------------
module cpu8_load_store_unit_top
  import cpu8ls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [4:0] op_class, [6:5] cycle_index, [9:7] dest_reg, [12:10] source_reg,
  // [14:13] pair_sel, [22:15] read_byte, [23] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [0] kind
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [1:0] bus_op, [17:2] bus_address, [25:18] write_byte, [26] done_res,
  // [42:27] pc_value, [46:43] target_written, [54:47] target_value, [55] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);

  logic       in_valid_q;
  in_item_t   in_q;
  logic       out_valid_q;
  out_item_t  out_q, out_d;
  logic       advance;

  logic [7:0]  regs_q [NumRegs];
  logic [7:0]  regs_d [NumRegs];
  logic [15:0] pc_q, pc_d;
  logic [15:0] temp_q, temp_d;
  logic [3:0]  pend_q, pend_d;
  logic [15:0] sp_q;

  logic [15:0] hl, pair_addr, pc1, pc2, high_c, high_t;
  logic [7:0]  src_val;
  logic [3:0]  dtgt;
  logic [1:0]  last, len;
  logic        active;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.target_value, out_q.target_written, out_q.pc_value,
                            out_q.done_res, out_q.write_byte, out_q.bus_address,
                            out_q.bus_op};

  assign hl     = {regs_q[REG_H], regs_q[REG_L]};
  assign pc1    = pc_q + 16'd1;
  assign pc2    = pc_q + 16'd2;
  assign high_c = {HighPageMsb, regs_q[REG_C]};
  assign high_t = {HighPageMsb, temp_q[7:0]};
  assign src_val = (in_q.source_reg < 3'(NumRegs)) ? regs_q[in_q.source_reg] : 8'd0;
  assign dtgt    = (in_q.dest_reg < 3'(NumRegs)) ? {1'b0, in_q.dest_reg} + 4'd1 : TGT_NONE;

  always_comb begin
    unique case (in_q.pair_sel)
      PAIR_BC: pair_addr = {regs_q[REG_B], regs_q[REG_C]};
      PAIR_DE: pair_addr = {regs_q[REG_D], regs_q[REG_E]};
      PAIR_HL: pair_addr = hl;
      default: pair_addr = sp_q;
    endcase
  end

  // final machine cycle and instruction length per form
  always_comb begin
    priority if (in_q.op_class == OP_MOV_RR) begin
      last = 2'd0; len = 2'd1;
    end else if (in_q.op_class == OP_LD_RN) begin
      last = 2'd1; len = 2'd2;
    end else if (in_q.op_class <= OP_LD_A_HLD || in_q.op_class == OP_ST_HIC_A
                 || in_q.op_class == OP_LD_A_HIC) begin
      last = 2'd1; len = 2'd1;
    end else if (in_q.op_class <= OP_LD_A_HIN) begin
      last = 2'd2; len = 2'd2;
    end else begin
      last = 2'd3; len = 2'd3;
    end
  end

  assign active = (in_q.op_class <= OP_ST_NN_A)
                  && (in_q.op_class == OP_MOV_RR
                      || (in_q.cycle_index != 2'd0 && in_q.cycle_index <= last));

  always_comb begin
    regs_d = regs_q;
    pc_d   = pc_q;
    temp_d = temp_q;
    pend_d = TGT_NONE;
    out_d  = '0;

    if (in_q.kind) begin
      // read return lands in the target recorded when the read went out
      if (pend_q >= TGT_REG_A && pend_q <= TGT_REG_L) begin
        regs_d[3'(pend_q - TGT_REG_A)] = in_q.read_byte;
        out_d.target_written = pend_q;
        out_d.target_value   = in_q.read_byte;
      end else if (pend_q == TGT_TEMP_LO) begin
        temp_d[7:0]          = in_q.read_byte;
        out_d.target_written = pend_q;
        out_d.target_value   = in_q.read_byte;
      end else if (pend_q == TGT_TEMP_HI) begin
        temp_d[15:8]         = in_q.read_byte;
        out_d.target_written = pend_q;
        out_d.target_value   = in_q.read_byte;
      end
    end else begin
      if (active) begin
        unique case (in_q.op_class)
          OP_MOV_RR: begin
            if (dtgt != TGT_NONE) begin
              regs_d[in_q.dest_reg] = src_val;
              out_d.target_written  = dtgt;
              out_d.target_value    = src_val;
            end
          end
          OP_LD_RN: begin
            out_d.bus_op = BUS_READ; out_d.bus_address = pc1; pend_d = dtgt;
          end
          OP_LD_R_HL: begin
            out_d.bus_op = BUS_READ; out_d.bus_address = hl; pend_d = dtgt;
          end
          OP_ST_HL_R: begin
            out_d.bus_op = BUS_WRITE; out_d.bus_address = hl; out_d.write_byte = src_val;
          end
          OP_ST_PAIR_A: begin
            out_d.bus_op      = BUS_WRITE;
            out_d.bus_address = pair_addr;
            out_d.write_byte  = regs_q[REG_A];
          end
          OP_LD_A_PAIR: begin
            out_d.bus_op = BUS_READ; out_d.bus_address = pair_addr; pend_d = TGT_REG_A;
          end
          OP_ST_HLI_A, OP_ST_HLD_A: begin
            out_d.bus_op      = BUS_WRITE;
            out_d.bus_address = hl;
            out_d.write_byte  = regs_q[REG_A];
            {regs_d[REG_H], regs_d[REG_L]} =
              (in_q.op_class == OP_ST_HLI_A) ? hl + 16'd1 : hl - 16'd1;
          end
          OP_LD_A_HLI, OP_LD_A_HLD: begin
            out_d.bus_op      = BUS_READ;
            out_d.bus_address = hl;
            pend_d            = TGT_REG_A;
            {regs_d[REG_H], regs_d[REG_L]} =
              (in_q.op_class == OP_LD_A_HLI) ? hl + 16'd1 : hl - 16'd1;
          end
          OP_ST_HL_N, OP_ST_HIN_A, OP_LD_A_HIN: begin
            if (in_q.cycle_index == 2'd1) begin
              out_d.bus_op = BUS_READ; out_d.bus_address = pc1; pend_d = TGT_TEMP_LO;
            end else if (in_q.op_class == OP_ST_HL_N) begin
              out_d.bus_op      = BUS_WRITE;
              out_d.bus_address = hl;
              out_d.write_byte  = temp_q[7:0];
            end else if (in_q.op_class == OP_ST_HIN_A) begin
              out_d.bus_op      = BUS_WRITE;
              out_d.bus_address = high_t;
              out_d.write_byte  = regs_q[REG_A];
            end else begin
              out_d.bus_op = BUS_READ; out_d.bus_address = high_t; pend_d = TGT_REG_A;
            end
          end
          OP_ST_HIC_A: begin
            out_d.bus_op      = BUS_WRITE;
            out_d.bus_address = high_c;
            out_d.write_byte  = regs_q[REG_A];
          end
          OP_LD_A_HIC: begin
            out_d.bus_op = BUS_READ; out_d.bus_address = high_c; pend_d = TGT_REG_A;
          end
          OP_LD_A_NN, OP_ST_NN_A: begin
            if (in_q.cycle_index == 2'd1) begin
              temp_d       = '0;
              out_d.bus_op = BUS_READ; out_d.bus_address = pc1; pend_d = TGT_TEMP_LO;
            end else if (in_q.cycle_index == 2'd2) begin
              out_d.bus_op = BUS_READ; out_d.bus_address = pc2; pend_d = TGT_TEMP_HI;
            end else if (in_q.op_class == OP_LD_A_NN) begin
              out_d.bus_op = BUS_READ; out_d.bus_address = temp_q; pend_d = TGT_REG_A;
            end else begin
              out_d.bus_op      = BUS_WRITE;
              out_d.bus_address = temp_q;
              out_d.write_byte  = regs_q[REG_A];
            end
          end
          default: ;
        endcase
      end
      // completion also covers a cycle index beyond the last one
      if (in_q.op_class <= OP_ST_NN_A && in_q.cycle_index >= last) begin
        out_d.done_res = 1'b1;
        pc_d           = pc_q + {14'd0, len};
      end
    end
    out_d.pc_value = pc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= '0;
      end
      pc_q   <= '0;
      temp_q <= '0;
      pend_q <= TGT_NONE;
      sp_q   <= StackRstVal;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        regs_q      <= regs_d;
        pc_q        <= pc_d;
        temp_q      <= temp_d;
        pend_q      <= pend_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        sp_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= {s_axis_tuser_i, op_class_e'(s_axis_tdata_i[4:0]), s_axis_tdata_i[6:5],
               s_axis_tdata_i[9:7], s_axis_tdata_i[12:10], s_axis_tdata_i[14:13],
               s_axis_tdata_i[22:15]};
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

@@ design/cpu8ls_sva.sv @@
// ----------------------------------------------------------------------------
// cpu8ls_sva
// Port-level checks of the load/store unit, bound to the top level.
// ----------------------------------------------------------------------------
module cpu8ls_sva
  import cpu8ls_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // taking a result always frees the input side
  a_ready_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |-> s_axis_tready_o)
    else $error("input not ready while output drains");

  // no bus request means empty address and write data
  a_idle_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] == BUS_NONE
      |-> m_axis_tdata_o[25:2] == 24'd0)
    else $error("address or data without bus request");

  // a register or temp write never comes with a bus write
  a_target_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[46:43] != TGT_NONE
      |-> m_axis_tdata_o[1:0] != BUS_WRITE && m_axis_tdata_o[26] == 1'b0
          || m_axis_tdata_o[1:0] == BUS_NONE)
    else $error("target write together with bus write");

endmodule

bind cpu8_load_store_unit_top cpu8ls_sva u_cpu8ls_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ bench/cpu8ls_load_checker.sv @@
// ----------------------------------------------------------------------------
// cpu8ls_load_checker
// Watches the input, output and stack address ports of the load/store unit.
// Keeps its own copy of the register file, PC, temp word and pending read
// target, predicts the result of every accepted item and compares it field by
// field with the results in order.
// ----------------------------------------------------------------------------
module cpu8ls_load_checker
  import cpu8ls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [InDataW-1:0]  s_data_i,
  input  logic                s_user_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [OutDataW-1:0] m_data_i,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  output int unsigned         err_cnt_o,
  output int unsigned         pend_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  regs [NumRegs];
  logic [15:0] pc_q;
  logic [15:0] temp_q;
  logic [15:0] sp_q;
  logic [3:0]  pend_tgt;
  out_item_t   results_q [$];
  int unsigned mism_cnt;

  function automatic logic [7:0] reg_or_zero(logic [2:0] idx);
    return (idx < NumRegs) ? regs[idx] : 8'h00;
  endfunction

  // advances the local copy of the unit by one item and returns its result
  function automatic out_item_t exec_load_item(logic kind, logic [InDataW-1:0] d);
    out_item_t   r;
    logic [4:0]  op;
    logic [1:0]  cyc;
    logic [2:0]  dst;
    logic [2:0]  src;
    logic [1:0]  pr;
    logic [7:0]  rb;
    logic [15:0] hl;
    logic [15:0] pair_addr;
    logic [3:0]  dtgt;
    logic [1:0]  last_cyc;
    logic [15:0] len;
    r = '0;
    {rb, pr, src, dst, cyc, op} = d[22:0];
    hl = {regs[REG_H], regs[REG_L]};
    if (kind) begin
      r.target_written = pend_tgt;
      if (pend_tgt >= TGT_REG_A && pend_tgt <= TGT_REG_L) begin
        regs[pend_tgt - TGT_REG_A] = rb;
      end else if (pend_tgt == TGT_TEMP_LO) begin
        temp_q[7:0] = rb;
      end else if (pend_tgt == TGT_TEMP_HI) begin
        temp_q[15:8] = rb;
      end else begin
        r.target_written = TGT_NONE;
      end
      if (r.target_written != TGT_NONE) r.target_value = rb;
      pend_tgt = TGT_NONE;
    end else begin
      // any tick drops a read that is still outstanding
      pend_tgt = TGT_NONE;
      dtgt = (dst < NumRegs) ? TGT_REG_A + dst : TGT_NONE;
      case (pr)
        PAIR_BC: pair_addr = {regs[REG_B], regs[REG_C]};
        PAIR_DE: pair_addr = {regs[REG_D], regs[REG_E]};
        PAIR_HL: pair_addr = hl;
        default: pair_addr = sp_q;
      endcase
      if (op == OP_MOV_RR) begin
        last_cyc = 2'd0; len = 16'd1;
      end else if (op == OP_LD_RN) begin
        last_cyc = 2'd1; len = 16'd2;
      end else if (op <= OP_LD_A_HLD || op == OP_ST_HIC_A || op == OP_LD_A_HIC) begin
        last_cyc = 2'd1; len = 16'd1;
      end else if (op <= OP_LD_A_HIN) begin
        last_cyc = 2'd2; len = 16'd2;
      end else begin
        last_cyc = 2'd3; len = 16'd3;
      end
      if (op <= OP_ST_NN_A && (op == OP_MOV_RR || (cyc != 2'd0 && cyc <= last_cyc))) begin
        case (op)
          OP_MOV_RR: begin
            if (dtgt != TGT_NONE) begin
              regs[dst] = reg_or_zero(src);
              r.target_written = dtgt;
              r.target_value = regs[dst];
            end
          end
          OP_LD_RN: begin
            r.bus_op = BUS_READ; r.bus_address = pc_q + 16'd1; pend_tgt = dtgt;
          end
          OP_LD_R_HL: begin
            r.bus_op = BUS_READ; r.bus_address = hl; pend_tgt = dtgt;
          end
          OP_ST_HL_R: begin
            r.bus_op = BUS_WRITE; r.bus_address = hl; r.write_byte = reg_or_zero(src);
          end
          OP_ST_PAIR_A: begin
            r.bus_op = BUS_WRITE; r.bus_address = pair_addr; r.write_byte = regs[REG_A];
          end
          OP_LD_A_PAIR: begin
            r.bus_op = BUS_READ; r.bus_address = pair_addr; pend_tgt = TGT_REG_A;
          end
          OP_ST_HLI_A, OP_ST_HLD_A: begin
            r.bus_op = BUS_WRITE; r.bus_address = hl; r.write_byte = regs[REG_A];
            {regs[REG_H], regs[REG_L]} = (op == OP_ST_HLI_A) ? hl + 16'd1 : hl - 16'd1;
          end
          OP_LD_A_HLI, OP_LD_A_HLD: begin
            r.bus_op = BUS_READ; r.bus_address = hl; pend_tgt = TGT_REG_A;
            {regs[REG_H], regs[REG_L]} = (op == OP_LD_A_HLI) ? hl + 16'd1 : hl - 16'd1;
          end
          OP_ST_HL_N, OP_ST_HIN_A, OP_LD_A_HIN: begin
            if (cyc == 2'd1) begin
              r.bus_op = BUS_READ; r.bus_address = pc_q + 16'd1; pend_tgt = TGT_TEMP_LO;
            end else if (op == OP_ST_HL_N) begin
              r.bus_op = BUS_WRITE; r.bus_address = hl; r.write_byte = temp_q[7:0];
            end else if (op == OP_ST_HIN_A) begin
              r.bus_op = BUS_WRITE; r.bus_address = {HighPageMsb, temp_q[7:0]};
              r.write_byte = regs[REG_A];
            end else begin
              r.bus_op = BUS_READ; r.bus_address = {HighPageMsb, temp_q[7:0]};
              pend_tgt = TGT_REG_A;
            end
          end
          OP_ST_HIC_A: begin
            r.bus_op = BUS_WRITE; r.bus_address = {HighPageMsb, regs[REG_C]};
            r.write_byte = regs[REG_A];
          end
          OP_LD_A_HIC: begin
            r.bus_op = BUS_READ; r.bus_address = {HighPageMsb, regs[REG_C]};
            pend_tgt = TGT_REG_A;
          end
          default: begin
            // absolute address forms: low byte, high byte, then the access
            if (cyc == 2'd1) begin
              temp_q = '0;
              r.bus_op = BUS_READ; r.bus_address = pc_q + 16'd1; pend_tgt = TGT_TEMP_LO;
            end else if (cyc == 2'd2) begin
              r.bus_op = BUS_READ; r.bus_address = pc_q + 16'd2; pend_tgt = TGT_TEMP_HI;
            end else if (op == OP_LD_A_NN) begin
              r.bus_op = BUS_READ; r.bus_address = temp_q; pend_tgt = TGT_REG_A;
            end else begin
              r.bus_op = BUS_WRITE; r.bus_address = temp_q; r.write_byte = regs[REG_A];
            end
          end
        endcase
      end
      if (op <= OP_ST_NN_A && cyc >= last_cyc) begin
        r.done_res = 1'b1;
        pc_q = pc_q + len;
      end
    end
    r.pc_value = pc_q;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mism_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      foreach (regs[i]) regs[i] = 8'h00;
      pc_q = '0;
      temp_q = '0;
      pend_tgt = TGT_NONE;
      sp_q = StackRstVal;
      results_q.delete();
      mism_cnt = 0;
    end else begin
      if (cfg_we_i) sp_q = cfg_wdata_i;
      if (m_valid_i && m_ready_i) begin
        if (results_q.size() == 0) begin
          $error("result with none outstanding: %h", m_data_i);
          mism_cnt++;
        end else begin
          want = results_q.pop_front();
          check_field("bus_op", want.bus_op, m_data_i[1:0]);
          check_field("bus_address", want.bus_address, m_data_i[17:2]);
          check_field("write_byte", want.write_byte, m_data_i[25:18]);
          check_field("done_res", want.done_res, m_data_i[26]);
          check_field("pc_value", want.pc_value, m_data_i[42:27]);
          check_field("target_written", want.target_written, m_data_i[46:43]);
          check_field("target_value", want.target_value, m_data_i[54:47]);
        end
      end
      if (s_valid_i && s_ready_i) results_q.push_back(exec_load_item(s_user_i, s_data_i));
    end
    err_cnt_o  <= mism_cnt;
    pend_cnt_o <= results_q.size();
  end

endmodule

@@ bench/cpu8_load_store_unit_top_tb.sv @@
// ----------------------------------------------------------------------------
// cpu8_load_store_unit_top_tb
// Drives instruction ticks and read returns into the load/store unit: a short
// directed opening on HL wrap, SP access, index 7, stray returns and dropped
// reads, then random instruction sequences under several stack addresses.
// Results are checked by the checker module.
// ----------------------------------------------------------------------------
module cpu8_load_store_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpu8ls_pkg::*;

  localparam logic [1:0] PAIR_SP       = 2'd3;
  localparam logic [2:0] REG_NONE      = 3'd7;
  localparam logic [4:0] OP_UNUSED_MAX = 5'd31;

  typedef enum int {RX_FREE, RX_COIN, RX_SLOW} rx_mode_e;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                s_valid   = 1'b0;
  logic [InDataW-1:0]  s_data    = '0;
  logic                s_user    = 1'b0;
  logic                m_ready   = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [15:0]         cfg_wdata = '0;
  logic                s_ready;
  logic                m_valid;
  logic [OutDataW-1:0] m_data;
  int unsigned         err_cnt;
  int unsigned         pend_cnt;

  int unsigned burst_left = 0;
  int unsigned sent_cnt   = 0;
  rx_mode_e    rx_mode    = RX_FREE;
  int unsigned rx_left    = 0;

  cpu8_load_store_unit_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  cpu8ls_load_checker u_load_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_valid_i   (s_valid),
    .s_ready_i   (s_ready),
    .s_data_i    (s_data),
    .s_user_i    (s_user),
    .m_valid_i   (m_valid),
    .m_ready_i   (m_ready),
    .m_data_i    (m_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: free running, coin toss, or one cycle in four
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(8, 64);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE: m_ready <= 1'b1;
      RX_COIN: m_ready <= 1'($urandom_range(0, 1));
      default: m_ready <= (rx_left[1:0] == 2'b00);
    endcase
  end

  function automatic logic [1:0] last_cycle(logic [4:0] op);
    if (op == OP_MOV_RR) return 2'd0;
    if (op <= OP_LD_A_HLD || op == OP_ST_HIC_A || op == OP_LD_A_HIC) return 2'd1;
    if (op <= OP_LD_A_HIN) return 2'd2;
    return 2'd3;
  endfunction

  // ticks that leave a read outstanding
  function automatic bit wants_return(logic [4:0] op, logic [1:0] cyc);
    case (op)
      OP_LD_RN, OP_LD_R_HL, OP_LD_A_PAIR, OP_LD_A_HLI, OP_LD_A_HLD, OP_LD_A_HIC,
      OP_ST_HL_N, OP_ST_HIN_A: return cyc == 2'd1;
      OP_LD_A_HIN, OP_ST_NN_A: return cyc == 2'd1 || cyc == 2'd2;
      OP_LD_A_NN:              return cyc != 2'd0;
      default:                 return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [2:0] pick_reg();
    return ($urandom_range(0, 15) == 0) ? REG_NONE : 3'($urandom_range(0, 6));
  endfunction

  task automatic send_item(input logic kind, input logic [4:0] op, input logic [1:0] cyc,
                           input logic [2:0] dst, input logic [2:0] src,
                           input logic [1:0] pr, input logic [7:0] rb);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {1'b0, rb, pr, src, dst, cyc, op};
    sent_cnt++;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  // one instruction with its read returns; a broken one loses returns or stops early
  task automatic run_instr(input logic [4:0] op, input bit broken);
    logic [2:0] dst;
    logic [2:0] src;
    logic [1:0] pr;
    int         c;
    dst = pick_reg();
    src = pick_reg();
    pr  = 2'($urandom_range(0, 3));
    for (c = 0; c <= int'(last_cycle(op)); c++) begin
      if (broken && c != 0 && $urandom_range(0, 3) == 0) break;
      if (c == 0 && op != OP_MOV_RR && $urandom_range(0, 7) == 0) continue;
      send_item(1'b0, op, 2'(c), dst, src, pr, 8'($urandom_range(0, 255)));
      if (wants_return(op, 2'(c)) && !(broken && $urandom_range(0, 1) == 1))
        send_item(1'b1, 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)),
                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  2'($urandom_range(0, 3)), pick_byte());
    end
  endtask

  task automatic random_step();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) run_instr(5'($urandom_range(0, 16)), 1'b0);
    else if (roll < 88) run_instr(5'($urandom_range(0, 16)), 1'b1);
    else send_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                   2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), pick_byte());
  endtask

  // hold the sender until every result has come back
  task automatic wait_idle();
    s_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] stack_vals [5];
    int unsigned phase_end;
    stack_vals = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000};
    stack_vals[3] = 16'($urandom_range(0, 65535));
    stack_vals[4] = 16'($urandom_range(0, 65535));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // HL <- 0x0000 through two immediate loads
    send_item(1'b0, OP_LD_RN, 2'd0, REG_H, REG_A, PAIR_BC, 8'h00);
    send_item(1'b0, OP_LD_RN, 2'd1, REG_H, REG_A, PAIR_BC, 8'h00);
    send_item(1'b1, OP_UNUSED_MAX, 2'd3, REG_NONE, REG_NONE, PAIR_SP, 8'h00);
    send_item(1'b0, OP_LD_RN, 2'd0, REG_L, REG_NONE, PAIR_SP, 8'hFF);
    send_item(1'b0, OP_LD_RN, 2'd1, REG_L, REG_NONE, PAIR_SP, 8'hFF);
    send_item(1'b1, OP_MOV_RR, 2'd0, REG_A, REG_A, PAIR_BC, 8'h00);
    // HL steps down through zero, then back up through 0xffff
    send_item(1'b0, OP_ST_HLD_A, 2'd0, REG_A, REG_A, PAIR_HL, 8'h00);
    send_item(1'b0, OP_ST_HLD_A, 2'd1, REG_A, REG_A, PAIR_HL, 8'h00);
    send_item(1'b0, OP_LD_A_HLI, 2'd0, REG_A, REG_A, PAIR_DE, 8'h00);
    send_item(1'b0, OP_LD_A_HLI, 2'd1, REG_A, REG_A, PAIR_DE, 8'h00);
    send_item(1'b1, OP_ST_NN_A, 2'd2, REG_L, REG_H, PAIR_DE, 8'hFF);
    // A <- (SP) at the reset stack address
    send_item(1'b0, OP_LD_A_PAIR, 2'd0, REG_A, REG_A, PAIR_SP, 8'h00);
    send_item(1'b0, OP_LD_A_PAIR, 2'd1, REG_A, REG_A, PAIR_SP, 8'h00);
    send_item(1'b1, OP_LD_A_PAIR, 2'd1, REG_A, REG_A, PAIR_SP, 8'h80);
    // index 7 as destination and as source
    send_item(1'b0, OP_MOV_RR, 2'd0, REG_NONE, REG_A, PAIR_BC, 8'h00);
    send_item(1'b0, OP_MOV_RR, 2'd0, REG_A, REG_NONE, PAIR_BC, 8'h00);
    // stray return, unused class, cycle past the end
    send_item(1'b1, OP_MOV_RR, 2'd0, REG_A, REG_A, PAIR_BC, 8'hFF);
    send_item(1'b0, OP_UNUSED_MAX, 2'd3, REG_NONE, REG_NONE, PAIR_SP, 8'hFF);
    send_item(1'b0, OP_LD_RN, 2'd3, REG_B, REG_C, PAIR_BC, 8'h00);
    // read with no target, then a tick that drops an outstanding read
    send_item(1'b0, OP_LD_RN, 2'd1, REG_NONE, REG_A, PAIR_BC, 8'h00);
    send_item(1'b1, OP_LD_RN, 2'd1, REG_B, REG_A, PAIR_BC, 8'hA5);
    send_item(1'b0, OP_LD_R_HL, 2'd1, REG_B, REG_A, PAIR_BC, 8'h00);
    send_item(1'b0, OP_MOV_RR, 2'd0, REG_C, REG_A, PAIR_BC, 8'h00);
    send_item(1'b1, OP_LD_R_HL, 2'd1, REG_B, REG_A, PAIR_BC, 8'h3C);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      cfg_we    <= 1'b1;
      cfg_wdata <= stack_vals[p];
      @(posedge clk);
      cfg_we    <= 1'b0;
      phase_end = sent_cnt + 330;
      while (sent_cnt < phase_end) random_step();
    end

    phase_end = sent_cnt + 120;
    while (sent_cnt < phase_end) random_step();

    wait_idle();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
